// ----- hw/rtl/tcf_pkg.sv -----
//------------------------------------------------------------------------------
// tcf_pkg
// Shared constants, types and the arctangent table for the tilt filter.
//------------------------------------------------------------------------------
`default_nettype none

package tcf_pkg;

    localparam int CordicStepsDef = 16;
    localparam int TableLen       = 24;
    localparam int PreShift       = 14;

    localparam logic [18:0] AngPi    = 19'd205887;
    localparam logic [18:0] AngTwoPi = 19'd411775;

    localparam logic [15:0] BlendWeightRst  = 16'd64250;
    localparam logic [15:0] SamplePeriodRst = 16'd655;

    // Register indexes
    localparam logic [0:0] RegBlend  = 1'b0;
    localparam logic [0:0] RegPeriod = 1'b1;

    // CORDIC x/y width: 17-bit magnitude << 14, plus growth and sign
    localparam int CW = 34;

    typedef struct packed {
        logic load;      // capture sample
        logic sq_start;  // start a square root pass
        logic sq_step;
        logic cd_start;  // start a CORDIC pass
        logic cd_step;
        logic axis;      // 0 = X angle, 1 = Y angle
        logic fold;      // fold CORDIC result into accel angle
        logic filt;      // run filter stage for axis
        logic filt2;     // second filter stage
        logic filt3;     // round the blend
        logic seed;      // start word: load both angles from accel angles
        logic commit;    // update word: store reduced angle for axis
    } t_cmd;

    function automatic logic [16:0] atan_lut(input logic [4:0] i);
        logic [16:0] v;
        case (i)
            5'd0: v = 17'd51472;
            5'd1: v = 17'd30386;
            5'd2: v = 17'd16055;
            5'd3: v = 17'd8150;
            5'd4: v = 17'd4091;
            5'd5: v = 17'd2047;
            5'd6: v = 17'd1024;
            5'd7: v = 17'd512;
            5'd8: v = 17'd256;
            5'd9: v = 17'd128;
            5'd10: v = 17'd64;
            5'd11: v = 17'd32;
            5'd12: v = 17'd16;
            5'd13: v = 17'd8;
            5'd14: v = 17'd4;
            5'd15: v = 17'd2;
            5'd16: v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tcf_if.sv -----
//------------------------------------------------------------------------------
// tcf_in_if / tcf_out_if
// Valid/ready channels carrying one IMU sample word and one tilt word.
//------------------------------------------------------------------------------
`default_nettype none

interface tcf_in_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [15:0] rate_x;
    logic [15:0] rate_y;
    modport source (output valid, kind, accel_x, accel_y, accel_z, rate_x, rate_y,
                    input ready);
    modport sink (input valid, kind, accel_x, accel_y, accel_z, rate_x, rate_y,
                  output ready);
endinterface

interface tcf_out_if;
    logic        valid;
    logic        ready;
    logic [18:0] tilt_x;
    logic [18:0] tilt_y;
    modport source (output valid, tilt_x, tilt_y, input ready);
    modport sink (input valid, tilt_x, tilt_y, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tilt_complementary_filter.sv -----
// The shared square-root unit (one bit a cycle) and CORDIC unit (one iteration a cycle) serve both
// axes in turn, so a new word is accepted only after the previous result word has been taken.
// The result word is held until taken; the next sample can be accepted in the cycle after it leaves.
// Reset (synchronous, active low) clears both angles to zero and loads the
// register defaults.
//------------------------------------------------------------------------------
// tilt_complementary_filter
// Two-axis complementary tilt filter with APB configuration.
//------------------------------------------------------------------------------
`default_nettype none

module tilt_complementary_filter import tcf_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tcf_in_if.sink      i_in,
    tcf_out_if.source   o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:2]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_blend, r_period;
    t_cmd        w_cmd;

    // Configuration registers
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend  <= BlendWeightRst;
            r_period <= SamplePeriodRst;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                RegBlend:  r_blend  <= pwdata[15:0];
                RegPeriod: r_period <= pwdata[15:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        case (paddr[2])
            RegBlend: prdata = {16'd0, r_blend};
            default:  prdata = {16'd0, r_period};
        endcase
    end

    tcf_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (w_cmd)
    );

    tcf_datapath #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_kind    (i_in.kind),
        .i_accel_x (i_in.accel_x),
        .i_accel_y (i_in.accel_y),
        .i_accel_z (i_in.accel_z),
        .i_rate_x  (i_in.rate_x),
        .i_rate_y  (i_in.rate_y),
        .i_blend   (r_blend),
        .i_period  (r_period),
        .o_tilt_x  (o_out.tilt_x),
        .o_tilt_y  (o_out.tilt_y)
    );

    // Input is never taken while a result word waits
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready) else $error("input ready while result pending");

    // Result angles stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.tilt_x < AngTwoPi) && (o_out.tilt_y < AngTwoPi))
        else $error("angle out of range");

    // Output held stable while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> $stable(o_out.tilt_x) && $stable(o_out.tilt_y))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

// ----- hw/rtl/tcf_datapath.sv -----
//------------------------------------------------------------------------------
// tcf_datapath
// Bit-serial square root, shared CORDIC vectoring unit and filter arithmetic.
//------------------------------------------------------------------------------
`default_nettype none

module tcf_datapath import tcf_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire t_cmd   i_cmd,
    input  wire         i_kind,
    input  wire  [15:0] i_accel_x,
    input  wire  [15:0] i_accel_y,
    input  wire  [15:0] i_accel_z,
    input  wire  [15:0] i_rate_x,
    input  wire  [15:0] i_rate_y,
    input  wire  [15:0] i_blend,
    input  wire  [15:0] i_period,
    output logic [18:0] o_tilt_x,
    output logic [18:0] o_tilt_y
);

    localparam int NSteps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

    // Captured sample
    logic               r_kind;
    logic signed [15:0] r_ax, r_ay, r_az, r_gx, r_gy;

    // Square root state (32-bit radicand, 33-bit remainder, 17-bit root register)
    logic [32:0] r_rem;
    logic [16:0] r_root;

    // CORDIC state
    logic signed [CW-1:0] r_cx, r_cy;
    logic signed [20:0]   r_cz;
    logic [4:0]           r_cd_i;

    // Accel angles and stored angles
    logic [18:0] r_acc_x, r_acc_y;
    logic [18:0] r_ang_x, r_ang_y;

    // Filter pipeline
    logic signed [36:0] r_gyro;   // comp*1024 + omega*period
    logic signed [20:0] r_acc;
    logic signed [56:0] r_mix_a;  // alpha * gyro
    logic signed [56:0] r_mix_b;  // (1-alpha) * acc*1024
    logic signed [31:0] r_res;

    // Operand select per axis
    logic signed [15:0] w_a, w_b;
    logic [31:0]        w_sq;
    logic [18:0]        w_stored, w_accang;
    logic signed [16:0] w_omega;
    always_comb begin
        w_a      = i_cmd.axis ? r_ay : r_ax;
        w_b      = i_cmd.axis ? r_ax : r_ay;
        w_sq     = 32'(w_b * w_b) + 32'(r_az * r_az);
        w_stored = i_cmd.axis ? r_ang_y : r_ang_x;
        w_accang = i_cmd.axis ? r_acc_y : r_acc_x;
        w_omega  = i_cmd.axis ? 17'(r_gx) : -17'(r_gy);
    end

    // Capture sample
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_ax <= i_accel_x;
            r_ay <= i_accel_y;
            r_az <= i_accel_z;
            r_gx <= i_rate_x;
            r_gy <= i_rate_y;
        end
    end

    // Restoring square root, one result bit per step, 16 steps
    logic [31:0] r_rad;
    logic [33:0] w_cur;
    logic [33:0] w_tst;
    always_comb begin
        w_cur = {r_rem[31:0], r_rad[31:30]};
        w_tst = {15'd0, r_root, 2'b01};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sq_start) begin
            r_rad  <= w_sq;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sq_step) begin
            r_rad <= {r_rad[29:0], 2'b00};
            if (w_cur >= w_tst) begin
                r_rem  <= 33'(w_cur - w_tst);
                r_root <= {r_root[15:0], 1'b1};
            end else begin
                r_rem  <= 33'(w_cur);
                r_root <= {r_root[15:0], 1'b0};
            end
        end
    end

    // CORDIC vectoring, one iteration per step
    logic signed [CW-1:0] w_xs, w_ys;
    logic [4:0]           w_idx;
    always_comb begin
        w_xs  = r_cx >>> r_cd_i;
        w_ys  = r_cy >>> r_cd_i;
        w_idx = r_cd_i;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cd_start) begin
            r_cx   <= CW'({1'b0, r_root}) <<< PreShift;
            r_cy   <= CW'(w_a) <<< PreShift;
            r_cz   <= '0;
            r_cd_i <= '0;
        end else if (i_cmd.cd_step) begin
            if (r_cd_i < 5'(NSteps)) begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + w_ys;
                    r_cy <= r_cy - w_xs;
                    r_cz <= r_cz + 21'(atan_lut(w_idx));
                end else if (r_cy < 0) begin
                    r_cx <= r_cx - w_ys;
                    r_cy <= r_cy + w_xs;
                    r_cz <= r_cz - 21'(atan_lut(w_idx));
                end
            end
            r_cd_i <= r_cd_i + 5'd1;
        end
    end

    // Fold into 0..2pi by sign of accel_z
    logic signed [20:0] w_fold;
    always_comb begin
        if (r_az < 0) begin
            w_fold = 21'(AngPi) - r_cz;
        end else if (r_cz < 0) begin
            w_fold = 21'(AngTwoPi) + r_cz;
        end else begin
            w_fold = r_cz;
        end
    end

    // Filter stage 1: unwrap and integrate
    logic signed [20:0] w_comp;
    logic signed [20:0] w_accs;
    always_comb begin
        w_comp = 21'(w_stored);
        w_accs = 21'(w_accang);
        if (w_comp > w_accs + 21'(AngPi)) begin
            w_comp = w_comp - 21'(AngTwoPi);
        end else if (w_accs > w_comp + 21'(AngPi)) begin
            w_comp = w_comp + 21'(AngTwoPi);
        end
    end

    // Filter stage 3: round, biased by 8*2pi so the result is never negative
    // (the rounded blend spans about -5.6 to +6.6 times 2pi).
    // Stage 4: reduce modulo 2pi with 8x, 4x, 2x and 1x compare/subtract steps.
    logic signed [56:0] w_mix;
    logic signed [31:0] w_r0;
    logic signed [31:0] w_red;
    logic signed [31:0] w_q;
    always_comb begin
        w_mix = r_mix_a + r_mix_b + 57'sd33554432 + (57'sd3294200 <<< 26);
        w_r0  = 32'(w_mix >>> 26);
        w_red = r_res;
        w_q   = w_red;
        if (w_q >= 32'sd3294200) w_q = w_q - 32'sd3294200;
        if (w_q >= 32'sd1647100) w_q = w_q - 32'sd1647100;
        if (w_q >= 32'sd823550)  w_q = w_q - 32'sd823550;
        if (w_q >= 32'sd411775)  w_q = w_q - 32'sd411775;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang_x <= '0;
            r_ang_y <= '0;
        end else begin
            if (i_cmd.fold) begin
                if (i_cmd.axis) r_acc_y <= 19'(w_fold);
                else            r_acc_x <= 19'(w_fold);
            end
            if (i_cmd.filt) begin
                r_gyro <= 37'(w_comp) * 37'sd1024 + 37'(w_omega * $signed({1'b0, i_period}));
                r_acc  <= w_accs;
            end
            if (i_cmd.filt2) begin
                r_mix_a <= 57'($signed({1'b0, i_blend})) * 57'(r_gyro);
                r_mix_b <= 57'(18'sd65536 - $signed({2'b0, i_blend}))
                           * 57'(r_acc) * 57'sd1024;
            end
            if (i_cmd.filt3) begin
                r_res <= w_r0;
            end
            // Load accel angles on a start word, store the blend on an update word
            if (i_cmd.seed) begin
                if (r_kind) begin
                    r_ang_x <= r_acc_x;
                    r_ang_y <= r_acc_y;
                end
            end else if (i_cmd.commit) begin
                if (!r_kind) begin
                    if (i_cmd.axis) r_ang_y <= 19'(w_q);
                    else            r_ang_x <= 19'(w_q);
                end
            end
        end
    end

    assign o_tilt_x = r_ang_x;
    assign o_tilt_y = r_ang_y;

endmodule

`default_nettype wire

// ----- hw/rtl/tcf_ctrl.sv -----
//------------------------------------------------------------------------------
// tcf_ctrl
// Sequencer: sqrt, CORDIC and fold per axis, then start-word seed and filter per axis.
//------------------------------------------------------------------------------
`default_nettype none

module tcf_ctrl import tcf_pkg::*; #(
    parameter int CORDIC_STEPS = CordicStepsDef
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output t_cmd        o_cmd
);

    localparam int NSteps = (CORDIC_STEPS < TableLen) ? CORDIC_STEPS : TableLen;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SQ0   = 4'd1;
    localparam logic [3:0] S_SQ    = 4'd2;
    localparam logic [3:0] S_CD0   = 4'd3;
    localparam logic [3:0] S_CD    = 4'd4;
    localparam logic [3:0] S_FOLD  = 4'd5;
    localparam logic [3:0] S_F1    = 4'd6;
    localparam logic [3:0] S_F2    = 4'd7;
    localparam logic [3:0] S_F3    = 4'd8;
    localparam logic [3:0] S_F4    = 4'd9;
    localparam logic [3:0] S_KIND  = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0] r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic       r_axis, n_axis;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_axis  = r_axis;
        o_cmd   = '0;
        o_cmd.axis = r_axis;
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = (r_state == S_OUT);
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_axis  = 1'b0;
                    n_state = S_SQ0;
                end
            end
            S_SQ0: begin
                o_cmd.sq_start = 1'b1;
                n_cnt   = '0;
                n_state = S_SQ;
            end
            S_SQ: begin
                o_cmd.sq_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd15) n_state = S_CD0;
            end
            S_CD0: begin
                o_cmd.cd_start = 1'b1;
                n_cnt   = '0;
                n_state = S_CD;
            end
            S_CD: begin
                o_cmd.cd_step = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'(NSteps - 1)) n_state = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold = 1'b1;
                if (r_axis) begin
                    n_axis  = 1'b0;
                    n_state = S_KIND;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_SQ0;
                end
            end
            S_KIND: begin
                // start word: load accel angles directly
                o_cmd.seed = 1'b1;
                n_state = S_F1;
            end
            S_F1: begin
                o_cmd.filt = 1'b1;
                n_state = S_F2;
            end
            S_F2: begin
                o_cmd.filt2 = 1'b1;
                n_state = S_F3;
            end
            S_F3: begin
                o_cmd.filt3 = 1'b1;
                n_state = S_F4;
            end
            S_F4: begin
                o_cmd.commit = 1'b1;
                if (r_axis) begin
                    n_state = S_OUT;
                end else begin
                    n_axis  = 1'b1;
                    n_state = S_F1;
                end
            end
            S_OUT: begin
                if (i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_axis  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_axis  <= n_axis;
        end
    end

endmodule

`default_nettype wire
